// ===== hdl/utf8_to_utf16_unit_decoder_top_defines.svh =====
// Assertion macros for the UTF-8 to UTF-16 unit decoder.
`ifndef UTF8_TO_UTF16_UNIT_DECODER_TOP_DEFINES_SVH
`define UTF8_TO_UTF16_UNIT_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define U8U16_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("u8u16 assertion failed");

`define U8U16_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("u8u16 forbidden condition seen");

`else

`define U8U16_ASSERT(lbl, clk, rst_n, prop)

`define U8U16_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== hdl/u8u16_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 unit decoder.
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned COUNT_W = 15;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

    // Decoder phase codes.
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_TWO     = 2'd1;
    localparam logic [1:0] PH_THREE_A = 2'd2;
    localparam logic [1:0] PH_THREE_B = 2'd3;

    // Depth of the result queue and its pointer / fill widths.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    typedef struct packed {
        logic [UNIT_W-1:0]  code_unit;
        logic               string_end;
        logic [COUNT_W-1:0] unit_total;
    } t_result;

endpackage

// ===== hdl/utf8_to_utf16_unit_decoder_top.sv =====
// Top level of the UTF-8 to UTF-16 unit decoder.
`timescale 1ns / 1ps
// Throughput: one input word per cycle; a word makes zero, one or two results, and the
// four-entry result queue drains one result per cycle while i_stall is low. The byte
// side stalls while a held word finds three or more results still waiting in the queue.
// Reset (i_rst_n low, synchronous) empties the input register and queue and idles the decoder.

`include "utf8_to_utf16_unit_decoder_top_defines.svh"

module utf8_to_utf16_unit_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_final_byte,
    // Code unit channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_code_unit,
    output logic        o_string_end,
    output logic [14:0] o_unit_total
);

    // ------------------------------------------------------------------
    // Input register. It holds one word until the decode step can place
    // its results; the queue must have room for two results to do so.
    // ------------------------------------------------------------------
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_fin;
    logic       advance;
    logic       in_take;

    logic [u8u16_pkg::QCNT_W-1:0] r_count;

    // Two free entries are guaranteed whether or not the queue pops.
    assign advance = r_in_valid &&
                     (r_count <= u8u16_pkg::QCNT_W'(u8u16_pkg::QDEPTH - 2));
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte <= i_text_byte;
            r_fin  <= i_final_byte;
        end
    end

    // ------------------------------------------------------------------
    // Decode step. It sees the registered byte and the pending sequence
    // state and produces up to two results in the same cycle. Only a
    // three-byte lead cut off by the end of the string gives two: the
    // held lead byte raw, then the final byte raw.
    // ------------------------------------------------------------------
    logic [1:0]  r_phase,  n_phase;
    logic [7:0]  r_lead,   n_lead;
    logic [7:0]  r_middle, n_middle;
    logic [14:0] r_units,  n_units;

    logic [1:0]           emit_n;
    logic [15:0]          unit0;
    logic [15:0]          unit1;
    logic [14:0]          cnt1;
    logic [14:0]          cnt2;
    u8u16_pkg::t_result   res0;
    u8u16_pkg::t_result   res1;

    // Each emitted unit bumps the string's count, saturating at the top.
    assign cnt1 = (r_units == u8u16_pkg::COUNT_MAX) ? r_units : r_units + 15'd1;
    assign cnt2 = (cnt1 == u8u16_pkg::COUNT_MAX) ? cnt1 : cnt1 + 15'd1;

    always_comb begin
        n_phase  = r_phase;
        n_lead   = r_lead;
        n_middle = r_middle;
        emit_n   = 2'd0;
        unit0    = {8'd0, r_byte};
        unit1    = {8'd0, r_byte};
        case (r_phase)
            u8u16_pkg::PH_IDLE: begin
                if (!r_byte[7]) begin
                    emit_n = 2'd1;
                end else if (r_byte[7:5] == 3'b110 && !r_fin) begin
                    n_lead  = r_byte;
                    n_phase = u8u16_pkg::PH_TWO;
                end else if (r_byte[7:4] == 4'hE && !r_fin) begin
                    n_lead  = r_byte;
                    n_phase = u8u16_pkg::PH_THREE_A;
                end else begin
                    // Stray continuation, four-byte lead, invalid byte, or a lead that ends the string.
                    emit_n = 2'd1;
                end
            end
            u8u16_pkg::PH_TWO: begin
                emit_n  = 2'd1;
                unit0   = {5'd0, r_lead[4:0], r_byte[5:0]};
                n_phase = u8u16_pkg::PH_IDLE;
            end
            u8u16_pkg::PH_THREE_A: begin
                if (r_fin) begin
                    emit_n  = 2'd2;
                    unit0   = {8'd0, r_lead};
                    n_phase = u8u16_pkg::PH_IDLE;
                end else begin
                    n_middle = r_byte;
                    n_phase  = u8u16_pkg::PH_THREE_B;
                end
            end
            u8u16_pkg::PH_THREE_B: begin
                emit_n  = 2'd1;
                unit0   = {r_lead[3:0], r_middle[5:0], r_byte[5:0]};
                n_phase = u8u16_pkg::PH_IDLE;
            end
            default: begin
                n_phase = u8u16_pkg::PH_IDLE;
            end
        endcase

        n_units = (emit_n == 2'd2) ? cnt2 : ((emit_n == 2'd1) ? cnt1 : r_units);

        // The end of a string always returns the decoder to a clean start.
        if (r_fin) begin
            n_phase  = u8u16_pkg::PH_IDLE;
            n_lead   = 8'd0;
            n_middle = 8'd0;
            n_units  = 15'd0;
        end

        res0.code_unit  = unit0;
        res0.string_end = r_fin && (emit_n == 2'd1);
        res0.unit_total = cnt1;
        res1.code_unit  = unit1;
        res1.string_end = r_fin;
        res1.unit_total = cnt2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= u8u16_pkg::PH_IDLE;
            r_units <= 15'd0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_units <= n_units;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_lead   <= n_lead;
            r_middle <= n_middle;
        end
    end

    // ------------------------------------------------------------------
    // Result queue. It is the output register: up to two writes per
    // cycle from the decode step, one read per cycle by the sink.
    // ------------------------------------------------------------------
    u8u16_pkg::t_result r_queue [u8u16_pkg::QDEPTH];

    logic [u8u16_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [u8u16_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [u8u16_pkg::QPTR_W-1:0] wr_ptr1;
    logic [1:0]                   push_n;
    logic                         pop;

    assign push_n  = advance ? emit_n : 2'd0;
    assign pop     = o_valid && !i_stall;
    assign wr_ptr1 = r_wr_ptr + u8u16_pkg::QPTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (push_n == 2'd2) begin
            r_queue[wr_ptr1] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + u8u16_pkg::QPTR_W'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + u8u16_pkg::QPTR_W'(1);
            end
            r_count <= r_count + u8u16_pkg::QCNT_W'(push_n)
                               - u8u16_pkg::QCNT_W'(pop);
        end
    end

    assign o_valid      = (r_count != '0);
    assign o_code_unit  = r_queue[r_rd_ptr].code_unit;
    assign o_string_end = r_queue[r_rd_ptr].string_end;
    assign o_unit_total = r_queue[r_rd_ptr].unit_total;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The queue never holds more results than it has entries.
    `U8U16_ASSERT_NEVER(a_queue_overflow, i_clk, i_rst_n,
        r_count > u8u16_pkg::QCNT_W'(u8u16_pkg::QDEPTH))
    // A decoded final word leaves the decoder idle with a zero count.
    `U8U16_ASSERT(a_fin_clears, i_clk, i_rst_n,
        (advance && r_fin) |=> (r_phase == u8u16_pkg::PH_IDLE && r_units == 15'd0))
    // The last unit of a string always carries a nonzero total.
    `U8U16_ASSERT(a_end_total, i_clk, i_rst_n,
        (o_valid && o_string_end) |-> (o_unit_total != 15'd0))

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the UTF-8 to UTF-16 unit decoder.
`timescale 1ns / 1ps

module tb;

    // One stimulus word together with the results it is known to cause. Rows that
    // leave fixed_exp low take their expected results from the decoder model below.
    typedef struct packed {
        logic [7:0]         b;
        logic               fin;
        logic               fixed_exp;
        logic [1:0]         exp_n;
        u8u16_pkg::t_result r0;
        u8u16_pkg::t_result r1;
    } t_row;

    localparam u8u16_pkg::t_result NO_UNIT = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_text_byte;
    logic        i_final_byte;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_code_unit;
    logic        o_string_end;
    logic [14:0] o_unit_total;

    utf8_to_utf16_unit_decoder_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_code_unit  (o_code_unit),
        .o_string_end (o_string_end),
        .o_unit_total (o_unit_total)
    );

    // 20 ns clock, low for the first half period.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // State of the decoder model. It mirrors the block's own state and is only
    // advanced when a word is accepted on the byte channel.
    logic [1:0]                    dec_phase   = u8u16_pkg::PH_IDLE;
    logic [7:0]                    held_lead   = '0;
    logic [7:0]                    held_middle = '0;
    logic [u8u16_pkg::COUNT_W-1:0] unit_count  = '0;

    // Code units that the block still owes, oldest first.
    u8u16_pkg::t_result expected_units [$];

    t_row cur_row;
    t_row dir_rows [0:24];
    int   mismatches  = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;

    // Emits one code unit from the model and bumps the per-string count, which
    // sticks at its maximum once it gets there.
    task automatic put_unit(input logic [15:0] u, input logic last,
                            output u8u16_pkg::t_result r);
        if (unit_count < u8u16_pkg::COUNT_MAX) begin
            unit_count++;
        end
        r.code_unit  = u;
        r.string_end = last;
        r.unit_total = unit_count;
    endtask

    // Decodes one input byte: zero, one or two code units come out of it.
    task automatic decode_byte(input logic [7:0] b, input logic fin, output int n,
                               output u8u16_pkg::t_result r0,
                               output u8u16_pkg::t_result r1);
        n  = 0;
        r0 = NO_UNIT;
        r1 = NO_UNIT;
        case (dec_phase)
            u8u16_pkg::PH_IDLE: begin
                if (b < 8'h80) begin
                    put_unit({8'h00, b}, fin, r0);
                    n = 1;
                end else if (b[7:5] == 3'b110 && !fin) begin
                    held_lead = b;
                    dec_phase = u8u16_pkg::PH_TWO;
                end else if (b[7:4] == 4'b1110 && !fin) begin
                    held_lead = b;
                    dec_phase = u8u16_pkg::PH_THREE_A;
                end else begin
                    // Stray continuation bytes, four-byte leads, 0xF8 and up, and leads that end the string go out raw.
                    put_unit({8'h00, b}, fin, r0);
                    n = 1;
                end
            end
            u8u16_pkg::PH_TWO: begin
                put_unit({5'b00000, held_lead[4:0], b[5:0]}, fin, r0);
                n = 1;
                dec_phase = u8u16_pkg::PH_IDLE;
            end
            u8u16_pkg::PH_THREE_A: begin
                if (fin) begin
                    // The string ends after the lead and one more byte: both go out raw,
                    // and only the second one closes the string.
                    put_unit({8'h00, held_lead}, 1'b0, r0);
                    put_unit({8'h00, b}, 1'b1, r1);
                    n = 2;
                    dec_phase = u8u16_pkg::PH_IDLE;
                end else begin
                    held_middle = b;
                    dec_phase = u8u16_pkg::PH_THREE_B;
                end
            end
            default: begin
                put_unit({held_lead[3:0], held_middle[5:0], b[5:0]}, fin, r0);
                n = 1;
                dec_phase = u8u16_pkg::PH_IDLE;
            end
        endcase
        if (fin) begin
            dec_phase   = u8u16_pkg::PH_IDLE;
            held_lead   = '0;
            held_middle = '0;
            unit_count  = '0;
        end
    endtask

    // Byte channel monitor. Every accepted word runs through the model; rows of the
    // directed table that carry their own results queue those instead.
    always @(posedge i_clk) begin : byte_monitor
        int                 n;
        u8u16_pkg::t_result r0;
        u8u16_pkg::t_result r1;
        if (i_rst_n && i_valid && !o_stall) begin
            decode_byte(i_text_byte, i_final_byte, n, r0, r1);
            if (cur_row.fixed_exp) begin
                n  = int'(cur_row.exp_n);
                r0 = cur_row.r0;
                r1 = cur_row.r1;
            end
            if (n > 0) begin
                expected_units.insert(expected_units.size(), r0);
            end
            if (n > 1) begin
                expected_units.insert(expected_units.size(), r1);
            end
        end
    end

    // Code unit channel checker: every accepted word is compared with the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin : unit_checker
        u8u16_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_units.size() == 0) begin
                $display("%0t: unexpected code unit %h (end %b, total %0d)", $time,
                         o_code_unit, o_string_end, o_unit_total);
                mismatches++;
            end else begin
                want = expected_units.pop_front();
                if (o_code_unit !== want.code_unit) begin
                    $display("%0t: code_unit expected %h, got %h", $time,
                             want.code_unit, o_code_unit);
                    mismatches++;
                end
                if (o_string_end !== want.string_end) begin
                    $display("%0t: string_end expected %b, got %b", $time,
                             want.string_end, o_string_end);
                    mismatches++;
                end
                if (o_unit_total !== want.unit_total) begin
                    $display("%0t: unit_total expected %0d, got %0d", $time,
                             want.unit_total, o_unit_total);
                    mismatches++;
                end
            end
        end
    end

    // The receiver stalls at random, at a rate the main sequence changes per phase.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    function automatic t_row plain_word(input logic [7:0] b, input logic fin);
        t_row w;
        w     = '0;
        w.b   = b;
        w.fin = fin;
        return w;
    endfunction

    // Offers one word on the byte channel and holds it until the block takes it.
    // Inputs only move at the falling edge; valid is touched once per edge.
    task automatic send_word(input t_row w);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_text_byte  <= w.b;
        i_final_byte <= w.fin;
        cur_row      <= w;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        @(negedge i_clk);
    endtask

    // Builds one string out of mostly well-formed characters with random content,
    // some noise bytes, and now and then a sequence cut short by the end of the string.
    // Returns how many words were sent.
    task automatic send_random_string(output int sent);
        logic [7:0] bytes [$];
        int         chars;
        int         kind;
        chars = $urandom_range(1, 10);
        for (int c = 0; c < chars; c++) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                bytes.insert(bytes.size(), 8'($urandom_range(0, 127)));
            end else if (kind < 55) begin
                bytes.insert(bytes.size(), {3'b110, 5'($urandom)});
                bytes.insert(bytes.size(), {2'b10, 6'($urandom)});
            end else if (kind < 75) begin
                bytes.insert(bytes.size(), {4'b1110, 4'($urandom)});
                bytes.insert(bytes.size(), {2'b10, 6'($urandom)});
                bytes.insert(bytes.size(), {2'b10, 6'($urandom)});
            end else if (kind < 85) begin
                bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
            end else begin
                // Continuation bytes are not checked, so any byte may follow a lead.
                bytes.insert(bytes.size(), {3'b110, 5'($urandom)});
                bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
            end
        end
        kind = $urandom_range(99);
        if (kind < 8) begin
            // The string ends on a lead byte.
            bytes.insert(bytes.size(), ($urandom_range(1) != 0) ? {3'b110, 5'($urandom)}
                                                                : {4'b1110, 4'($urandom)});
        end else if (kind < 16) begin
            // The string ends one byte into a three-byte sequence.
            bytes.insert(bytes.size(), {4'b1110, 4'($urandom)});
            bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
        end
        foreach (bytes[k]) begin
            send_word(plain_word(bytes[k], k == bytes.size() - 1));
        end
        sent = bytes.size();
    endtask

    // Runs random strings until about the given number of words has gone in.
    task automatic random_phase(input int words);
        int done;
        int sent;
        done = 0;
        while (done < words) begin
            send_random_string(sent);
            done += sent;
        end
    endtask

    initial begin : main_sequence
        int waited;

        // Everything starts at a known value and the block is held in reset.
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_text_byte  = '0;
        i_final_byte = 1'b0;
        i_stall      = 1'b0;
        cur_row      = '0;

        // Directed table. Rows whose results are obvious carry them; joined
        // multi-byte units are left to the decoder model.
        dir_rows = '{
            // Smallest and largest single-byte characters.
            '{8'h00, 1'b0, 1'b1, 2'd1, '{16'h0000, 1'b0, 15'd1}, NO_UNIT},
            '{8'h7F, 1'b1, 1'b1, 2'd1, '{16'h007F, 1'b1, 15'd2}, NO_UNIT},
            // Two-byte character that ends the string.
            '{8'hC3, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
            '{8'hA9, 1'b1, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
            // Three-byte character that ends the string.
            '{8'hE2, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
            '{8'h82, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
            '{8'hAC, 1'b1, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
            // Largest three-byte and two-byte units in the middle of a string.
            '{8'hEF, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
            '{8'hBF, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
            '{8'hBF, 1'b0, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
            '{8'hDF, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
            '{8'hBF, 1'b0, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
            // Stray continuation, 0xFF and a four-byte lead all go out raw.
            '{8'h80, 1'b0, 1'b1, 2'd1, '{16'h0080, 1'b0, 15'd3}, NO_UNIT},
            '{8'hFF, 1'b0, 1'b1, 2'd1, '{16'h00FF, 1'b0, 15'd4}, NO_UNIT},
            '{8'hF0, 1'b0, 1'b1, 2'd1, '{16'h00F0, 1'b0, 15'd5}, NO_UNIT},
            // A lead byte that is the last byte of its string goes out raw.
            '{8'hC0, 1'b1, 1'b1, 2'd1, '{16'h00C0, 1'b1, 15'd6}, NO_UNIT},
            '{8'hE0, 1'b1, 1'b1, 2'd1, '{16'h00E0, 1'b1, 15'd1}, NO_UNIT},
            // The string ends one byte into a three-byte sequence: two raw units.
            '{8'hE5, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
            '{8'h41, 1'b1, 1'b1, 2'd2, '{16'h00E5, 1'b0, 15'd1}, '{16'h0041, 1'b1, 15'd2}},
            // Three-byte sequence closed by the final byte.
            '{8'hED, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
            '{8'hA0, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
            '{8'h00, 1'b1, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
            // A continuation byte that is not one is taken all the same.
            '{8'hC2, 1'b0, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
            '{8'h00, 1'b0, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
            '{8'hFF, 1'b1, 1'b1, 2'd1, '{16'h00FF, 1'b1, 15'd2}, NO_UNIT}
        };

        // Reset is held low from the start and is released at a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // First phase: the sender rarely idles while the receiver stalls most of the time.
        tx_idle_pct = 13;
        rx_idle_pct = 83;
        foreach (dir_rows[k]) begin
            send_word(dir_rows[k]);
        end
        random_phase(230);

        // Second phase: a sparse sender facing a receiver that is mostly ready.
        tx_idle_pct = 83;
        rx_idle_pct = 13;
        random_phase(240);

        // Last phase: no idling on either side, so words go in back to back.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(240);
        i_valid <= 1'b0;

        // Drain whatever is still owed, then keep the clock running so that any result
        // that should not be there still shows.
        waited = 0;
        while (expected_units.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (expected_units.size() != 0) begin
            $display("%0t: %0d code units never arrived, next expected %h", $time,
                     expected_units.size(), expected_units[0].code_unit);
            mismatches++;
        end

        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Guards against a hung handshake; the slowest correct run needs well under this.
    initial begin
        #20_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
